// ----- hdl/dbs_pkg.sv -----
package dbs_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W = 16;
  localparam int BIT_POS_W = 3;
  localparam int BYTE_POS_W = CNT_W - BIT_POS_W;
  localparam int BRIGHT_W = 3;
  localparam int FRAME_LEN = 10;
  localparam int PHASE_W = 4;
  localparam int OUT_PAYLOADS = 5;
  localparam int DEF_PAYLOAD_BYTES = 5;

  localparam logic [BYTE_W-1:0] WRITE_CMD_RESET = 8'hC0;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd7;
  localparam logic [BYTE_W-1:0] CTRL_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CTRL_CODE = 8'h80;
  localparam logic [CNT_W-1:0] CTRL_LAST_BIT = 16'd7;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(FRAME_LEN - 1);

  // Reply frame framing: a low start bit below the key, high stop bits above it.
  localparam logic START_BIT = 1'b0;
  localparam logic [6:0] STOP_BITS = 7'h7F;

  typedef enum logic {
    EV_CLOCK = 1'b0,
    EV_DATA  = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic              event_kind;
    logic              clk_level;
    logic              ld_level;
    logic [BYTE_W-1:0] key_byte;
  } dbs_event_t;

  typedef struct packed {
    logic       valid;
    dbs_event_t ev;
  } dbs_stage_t;

  // Bit of the reply frame sent at a given frame position.
  function automatic logic frame_bit(input logic [BYTE_W-1:0] key,
                                     input logic [PHASE_W-1:0] phase);
    logic [15:0] frame;
    frame = {STOP_BITS, key, START_BIT};
    return frame[phase];
  endfunction

endpackage

// ----- hdl/dbs_interfaces.sv -----
interface dbs_in_if;
  import dbs_pkg::*;
  logic              valid;
  logic              ready;
  logic              event_kind;
  logic              clk_level;
  logic              ld_level;
  logic [BYTE_W-1:0] key_byte;

  modport source(output valid, event_kind, clk_level, ld_level, key_byte, input ready);
  modport sink(input valid, event_kind, clk_level, ld_level, key_byte, output ready);
endinterface

interface dbs_out_if;
  import dbs_pkg::*;
  logic                valid;
  logic                ready;
  logic                td_drive;
  logic                td_level;
  logic                packet_done;
  logic                bus_busy;
  logic [BRIGHT_W-1:0] brightness;
  logic [BYTE_W-1:0]   payload_0;
  logic [BYTE_W-1:0]   payload_1;
  logic [BYTE_W-1:0]   payload_2;
  logic [BYTE_W-1:0]   payload_3;
  logic [BYTE_W-1:0]   payload_4;

  modport source(output valid, td_drive, td_level, packet_done, bus_busy, brightness,
                 payload_0, payload_1, payload_2, payload_3, payload_4, input ready);
  modport sink(input valid, td_drive, td_level, packet_done, bus_busy, brightness,
               payload_0, payload_1, payload_2, payload_3, payload_4, output ready);
endinterface

interface dbs_cfg_if;
  import dbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- hdl/display_bus_snoop_and_key_reply.sv -----
// Serial display bus snooper with key reply. Each transaction on events is one
// bus edge (clock or data change); each gives exactly one transaction on results
// once results is ready, and a new event is taken every cycle while results is
// ready: one input register and one result register with a single pass of logic
// between them, where the bus state is updated. A data change while the clock is
// high is a start (data low) or stop (data high, packet_done pulses). Rising clocks
// shift data LSB first into the command byte and, after the write command set
// through cfg, into the payload bytes; falling clocks report the next bit of the
// reply frame (low start bit, key byte LSB first, high stop bit). The user must
// write configuration only while no event is in flight; the block does not enforce it.
module display_bus_snoop_and_key_reply #(
  parameter int PAYLOAD_BYTES = dbs_pkg::DEF_PAYLOAD_BYTES
) (
  input logic       clk,
  input logic       rst,
  dbs_in_if.sink    events,
  dbs_cfg_if.sink   cfg,
  dbs_out_if.source results
);
  import dbs_pkg::*;

  dbs_stage_t stage;
  logic       advance;

  dbs_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .events  (events),
    .advance (advance),
    .stage   (stage)
  );

  dbs_engine #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .cfg     (cfg),
    .results (results)
  );

endmodule

// ----- hdl/dbs_in_stage.sv -----
module dbs_in_stage (
  input  logic               clk,
  input  logic               rst,
  dbs_in_if.sink             events,
  input  logic               advance,
  output dbs_pkg::dbs_stage_t stage
);
  import dbs_pkg::*;

  logic       valid;
  dbs_event_t ev;

  // The register takes a new transaction when empty or when it moves on.
  assign events.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (events.ready) begin
      valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      ev.event_kind <= events.event_kind;
      ev.clk_level  <= events.clk_level;
      ev.ld_level   <= events.ld_level;
      ev.key_byte   <= events.key_byte;
    end
  end

  assign stage.valid = valid;
  assign stage.ev    = ev;

endmodule

// ----- hdl/dbs_engine.sv -----
module dbs_engine #(
  parameter int PAYLOAD_BYTES = dbs_pkg::DEF_PAYLOAD_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  dbs_pkg::dbs_stage_t stage,
  output logic                advance,
  dbs_cfg_if.sink             cfg,
  dbs_out_if.source           results
);
  import dbs_pkg::*;

  // Bus state.
  logic [CNT_W-1:0]    bit_counter, bit_counter_next;
  logic [PHASE_W-1:0]  phase, phase_next;
  logic [BYTE_W-1:0]   command_byte, command_byte_next;
  logic [BRIGHT_W-1:0] brightness_reg, brightness_reg_next;
  logic                busy_flag, busy_flag_next;
  logic [BYTE_W-1:0]   payload_store [PAYLOAD_BYTES];
  logic [BYTE_W-1:0]   write_command;

  // Result register.
  logic res_valid, td_drive, td_level, packet_done;
  logic td_drive_next, td_level_next, packet_done_next;

  logic                  fire;
  logic [BIT_POS_W-1:0]  bit_pos;
  logic [BYTE_POS_W-1:0] byte_pos;
  logic                  rising, cond_event, pay_write;

  assign advance  = !res_valid || results.ready;
  assign fire     = stage.valid && advance;
  assign bit_pos  = bit_counter[BIT_POS_W-1:0];
  assign byte_pos = bit_counter[CNT_W-1:BIT_POS_W];

  assign cond_event = (stage.ev.event_kind == EV_DATA) && stage.ev.clk_level;
  assign rising     = (stage.ev.event_kind == EV_CLOCK) && stage.ev.clk_level;
  assign pay_write  = rising && (byte_pos != '0)
                      && (byte_pos <= BYTE_POS_W'(PAYLOAD_BYTES))
                      && (command_byte == write_command);

  // Configuration register; the user must write it only while the block is idle, the block does not enforce this.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_command <= WRITE_CMD_RESET;
    end else if (cfg.valid) begin
      write_command <= cfg.data;
    end
  end

  // Next state and result for the transaction in the input register.
  always_comb begin
    bit_counter_next    = bit_counter;
    phase_next          = phase;
    command_byte_next   = command_byte;
    brightness_reg_next = brightness_reg;
    busy_flag_next      = busy_flag;
    td_drive_next       = 1'b0;
    td_level_next       = 1'b0;
    packet_done_next    = 1'b0;
    if (cond_event) begin
      // Start when data falls, stop when it rises, both with the clock high.
      bit_counter_next  = '0;
      phase_next        = '0;
      command_byte_next = '0;
      busy_flag_next    = !stage.ev.ld_level;
      packet_done_next  = stage.ev.ld_level;
    end else if (rising) begin
      if (byte_pos == '0) begin
        command_byte_next = command_byte
                            | (BYTE_W'(stage.ev.ld_level) << bit_pos);
      end
      if ((bit_counter == CTRL_LAST_BIT)
          && ((command_byte_next & CTRL_MASK) == CTRL_CODE)) begin
        brightness_reg_next = command_byte_next[BRIGHT_W-1:0];
      end
      bit_counter_next = bit_counter + 1'b1;
      // The frame position follows the counter modulo the frame length,
      // including the jump back to zero when the counter wraps.
      if ((bit_counter == {CNT_W{1'b1}}) || (phase == PHASE_LAST)) begin
        phase_next = '0;
      end else begin
        phase_next = phase + 1'b1;
      end
    end else if (stage.ev.event_kind == EV_CLOCK) begin
      // Falling clock: send the current reply frame bit.
      td_drive_next = 1'b1;
      td_level_next = frame_bit(stage.ev.key_byte, phase);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_counter    <= '0;
      phase          <= '0;
      command_byte   <= '0;
      brightness_reg <= BRIGHT_RESET;
      busy_flag      <= 1'b0;
    end else if (fire) begin
      bit_counter    <= bit_counter_next;
      phase          <= phase_next;
      command_byte   <= command_byte_next;
      brightness_reg <= brightness_reg_next;
      busy_flag      <= busy_flag_next;
    end
  end

  // Payload bytes: the entry selected by the byte position takes the data bit.
  always_ff @(posedge clk) begin
    for (int e = 0; e < PAYLOAD_BYTES; e++) begin
      if (rst) begin
        payload_store[e] <= '0;
      end else if (fire && pay_write && (byte_pos == BYTE_POS_W'(e + 1))) begin
        payload_store[e][bit_pos] <= stage.ev.ld_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      td_drive    <= td_drive_next;
      td_level    <= td_level_next;
      packet_done <= packet_done_next;
    end
  end

  // State registers change only when a new result is loaded, so they
  // always describe the result on the output.
  logic [BYTE_W-1:0] pay_view [OUT_PAYLOADS];

  for (genvar j = 0; j < OUT_PAYLOADS; j++) begin : g_view
    if (j < PAYLOAD_BYTES) begin : g_live
      assign pay_view[j] = payload_store[j];
    end else begin : g_none
      assign pay_view[j] = '0;
    end
  end

  assign results.valid       = res_valid;
  assign results.td_drive    = td_drive;
  assign results.td_level    = td_level;
  assign results.packet_done = packet_done;
  assign results.bus_busy    = busy_flag;
  assign results.brightness  = brightness_reg;
  assign results.payload_0   = pay_view[0];
  assign results.payload_1   = pay_view[1];
  assign results.payload_2   = pay_view[2];
  assign results.payload_3   = pay_view[3];
  assign results.payload_4   = pay_view[4];

endmodule
